/* rtl/dlf_pkg.sv */
// shared types and constants for the door lamp fader
`default_nettype none

package dlf_pkg;

   // fixed field widths of the ports
   localparam int SENSOR_W = 4;
   localparam int OUT_CH   = 4;
   localparam int OUT_LVL_W = 16;
   localparam int CNT_W    = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   // register reset values
   localparam logic [CNT_W-1:0]     DEBOUNCE_RST = 16'd50;
   localparam logic [CNT_W-1:0]     FADE_STEP_RST = 16'd64;
   localparam logic [OUT_LVL_W-1:0] FULL_LEVEL_RST = 16'hFFFF;
   localparam logic [SENSOR_W-1:0]  POLARITY_RST = 4'hF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEBOUNCE   = 2'd0,
      CSR_FADE_STEP  = 2'd1,
      CSR_FULL_LEVEL = 2'd2,
      CSR_POLARITY   = 2'd3
   } dlf_csr_type;

   typedef struct packed {
      logic [CNT_W-1:0]     debounce_ticks;
      logic [CNT_W-1:0]     ramp_step;
      logic [OUT_LVL_W-1:0] full_level;
      logic [SENSOR_W-1:0]  polarity_low;
   } dlf_cfg_type;

   // per-channel flag bits going into the channel update
   typedef struct packed {
      logic now;
      logic prev;
      logic pol;
      logic lamp;
      logic fading;
   } dlf_chin_type;

   // per-channel flag bits coming out of the channel update
   typedef struct packed {
      logic lamp;
      logic fading;
   } dlf_chout_type;

   typedef struct packed {
      logic [OUT_CH-1:0][OUT_LVL_W-1:0] level;
      logic [OUT_CH-1:0]                lamp_on;
      logic [OUT_CH-1:0]                fading;
   } dlf_rsp_type;

endpackage

`default_nettype wire

/* rtl/dlf_ram.sv */
// generic single-port-write, registered-read ram
`default_nettype none

module dlf_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 4,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first: a same-cycle write is not seen by the read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/dlf_chan_update.sv */
// debounce, lamp switching and one fade move for a single channel
`default_nettype none

module dlf_chan_update #(
   parameter int LEVEL_BITS = 16
) (
   input  wire dlf_pkg::dlf_cfg_type           cfg,
   input  wire dlf_pkg::dlf_chin_type          flags,
   input  wire logic [dlf_pkg::CNT_W-1:0]      ticks,
   input  wire logic [LEVEL_BITS-1:0]          target,
   input  wire logic [LEVEL_BITS-1:0]          current,
   output logic      [dlf_pkg::CNT_W-1:0]      ticks_new,
   output logic      [LEVEL_BITS-1:0]          target_new,
   output logic      [LEVEL_BITS-1:0]          current_new,
   output dlf_pkg::dlf_chout_type              flags_new
);

   import dlf_pkg::*;

   localparam int SUM_W = CNT_W + 1;

   logic [CNT_W-1:0]      ticks_inc;
   logic                  change;
   logic                  is_open;
   logic [LEVEL_BITS-1:0] full_lvl;
   logic [LEVEL_BITS-1:0] tgt;
   logic                  fad;
   logic                  lamp;
   logic [SUM_W-1:0]      sum;
   logic [CNT_W-1:0]      cur_w;
   logic [CNT_W-1:0]      diff;
   logic [LEVEL_BITS-1:0] nxt;

   always_comb begin
      ticks_inc = (ticks != CNT_MAX) ? ticks + 1'b1 : ticks;
      change    = (flags.now != flags.prev) && (ticks_inc >= cfg.debounce_ticks);
      is_open   = flags.pol ? !flags.now : flags.now;
      full_lvl  = LEVEL_BITS'(cfg.full_level);
      ticks_new = change ? '0 : ticks_inc;

      tgt  = target;
      fad  = flags.fading;
      lamp = flags.lamp;
      if (change && is_open && !flags.lamp) begin
         lamp = 1'b1;
         if (tgt != full_lvl) begin
            tgt = full_lvl;
            fad = 1'b1;
         end
      end else if (change && !is_open && flags.lamp) begin
         lamp = 1'b0;
         if (tgt != '0) begin
            tgt = '0;
            fad = 1'b1;
         end
      end

      // one fade move; up clamps at target, down floors at zero
      cur_w = CNT_W'(current);
      sum   = SUM_W'(current) + SUM_W'(cfg.ramp_step);
      diff  = cur_w - cfg.ramp_step;
      nxt   = current;
      if (fad) begin
         if (current == tgt) begin
            fad = 1'b0;
         end else begin
            if (current < tgt) begin
               nxt = (sum > SUM_W'(tgt)) ? tgt : LEVEL_BITS'(sum);
            end else begin
               nxt = (cur_w > cfg.ramp_step) ? LEVEL_BITS'(diff) : '0;
            end
            if (nxt == tgt) begin
               fad = 1'b0;
            end
         end
      end

      target_new       = tgt;
      current_new      = nxt;
      flags_new.lamp   = lamp;
      flags_new.fading = fad;
   end

endmodule

`default_nettype wire

/* rtl/dlf_out_buf.sv */
// two-entry result buffer with skid slot
`default_nettype none

module dlf_out_buf (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire dlf_pkg::dlf_rsp_type push_data,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output dlf_pkg::dlf_rsp_type      out_data
);

   import dlf_pkg::*;

   logic        main_v_ff;
   logic        main_v_in;
   logic        skid_v_ff;
   logic        skid_v_in;
   dlf_rsp_type main_ff;
   dlf_rsp_type main_in;
   dlf_rsp_type skid_ff;
   dlf_rsp_type skid_in;
   logic        take;

   assign take = main_v_ff && out_ready;

   always_comb begin
      main_v_in = main_v_ff;
      skid_v_in = skid_v_ff;
      main_in   = main_ff;
      skid_in   = skid_ff;
      if (take) begin
         if (skid_v_ff) begin
            main_in   = skid_ff;
            skid_v_in = push;
            skid_in   = push_data;
         end else begin
            main_v_in = push;
            main_in   = push_data;
         end
      end else if (!main_v_ff) begin
         main_v_in = push;
         main_in   = push_data;
      end else if (push) begin
         skid_v_in = 1'b1;
         skid_in   = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         main_v_ff <= main_v_in;
         skid_v_ff <= skid_v_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign out_valid = main_v_ff;
   assign out_data  = main_ff;

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> main_v_ff)
      else $error("skid slot holds a beat while the main slot is empty");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && main_v_ff && skid_v_ff && !out_ready))
      else $error("result beat pushed into a full buffer");

   a_hold_until_taken: assert property (@(posedge clock) disable iff (reset)
      (main_v_ff && !out_ready) |=> (main_v_ff && $stable(main_ff)))
      else $error("offered result beat changed before it was taken");

endmodule

`default_nettype wire

/* rtl/debounced_door_lamp_fader_unit.sv */
// top level of the debounced door lamp fader
// a result beat shows on rsp_valid once its last channel has passed the update stage into
//   the result buffer; the sequencer reads and writes back one ram channel state entry per
//   cycle and takes a new beat when idle or on its last channel with under two results pending
// reset: clears sequencer, flag bits, entry valid bits, result buffer and loads the
//   register reset values; ram contents are masked by valid bits, so no clearing pass
`default_nettype none

module debounced_door_lamp_fader_unit #(
   parameter int CHANNELS   = 4,
   parameter int LEVEL_BITS = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // input channel
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [dlf_pkg::SENSOR_W-1:0]     req_sensor_levels,
   // result channel
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic      [dlf_pkg::OUT_LVL_W-1:0]    rsp_level_ch0,
   output logic      [dlf_pkg::OUT_LVL_W-1:0]    rsp_level_ch1,
   output logic      [dlf_pkg::OUT_LVL_W-1:0]    rsp_level_ch2,
   output logic      [dlf_pkg::OUT_LVL_W-1:0]    rsp_level_ch3,
   output logic      [dlf_pkg::SENSOR_W-1:0]     rsp_lamp_on_mask,
   output logic      [dlf_pkg::SENSOR_W-1:0]     rsp_fading_mask,
   // register write port
   input  wire logic                             csr_wr_en,
   input  wire logic [dlf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [dlf_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import dlf_pkg::*;

   localparam int CH_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int WORD_W  = CNT_W + 2 * LEVEL_BITS;
   // ram word layout: {ticks, target, current}
   localparam int CUR_LO  = 0;
   localparam int TGT_LO  = LEVEL_BITS;
   localparam int TCK_LO  = 2 * LEVEL_BITS;
   localparam logic [CH_BITS-1:0] CH_LAST = CH_BITS'(CHANNELS - 1);
   localparam logic [1:0] PEND_MAX = 2'd2;

   // ---------------- configuration registers ----------------
   dlf_cfg_type cfg_ff;
   dlf_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (dlf_csr_type'(csr_index))
            CSR_DEBOUNCE:   cfg_in.debounce_ticks = CNT_W'(csr_wdata);
            CSR_FADE_STEP:  cfg_in.ramp_step      = CNT_W'(csr_wdata);
            CSR_FULL_LEVEL: cfg_in.full_level     = OUT_LVL_W'(csr_wdata);
            CSR_POLARITY:   cfg_in.polarity_low   = SENSOR_W'(csr_wdata);
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks <= DEBOUNCE_RST;
         cfg_ff.ramp_step      <= FADE_STEP_RST;
         cfg_ff.full_level     <= FULL_LEVEL_RST;
         cfg_ff.polarity_low   <= POLARITY_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------- channel sequencer (read stage) ----------------
   // busy_ff: an item is walking its channels, ch_ff is read from the ram this cycle
   logic                busy_ff;
   logic                busy_in;
   logic [CH_BITS-1:0]  ch_ff;
   logic [CH_BITS-1:0]  ch_in;
   logic [SENSOR_W-1:0] sens_ff;
   logic [SENSOR_W-1:0] sens_in;
   logic                ch_last;
   logic                req_take;
   logic                rsp_take;
   // beats accepted whose result has not left yet; bounded by the buffer depth
   logic [1:0]          pend_ff;
   logic [1:0]          pend_in;

   assign ch_last   = (ch_ff == CH_LAST);
   assign req_ready = (!busy_ff || ch_last) && (pend_ff < PEND_MAX);
   assign req_take  = req_valid && req_ready;
   assign rsp_take  = rsp_valid && rsp_ready;

   always_comb begin
      busy_in = busy_ff && !ch_last;
      ch_in   = ch_ff;
      sens_in = sens_ff;
      if (req_take) begin
         busy_in = 1'b1;
         ch_in   = '0;
         sens_in = req_sensor_levels;
      end else if (busy_ff) begin
         ch_in = ch_last ? '0 : ch_ff + 1'b1;
      end
      pend_in = pend_ff + {1'b0, req_take} - {1'b0, rsp_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         ch_ff   <= '0;
         pend_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         ch_ff   <= ch_in;
         pend_ff <= pend_in;
      end
      sens_ff <= sens_in;
   end

   // ---------------- channel state ram ----------------
   logic                wr_en;
   logic [CH_BITS-1:0]  wr_addr;
   logic [WORD_W-1:0]   wr_word;
   logic [WORD_W-1:0]   rd_word;

   dlf_ram #(
      .WIDTH (WORD_W),
      .DEPTH (CHANNELS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_word),
      .rd_en   (busy_ff),
      .rd_addr (ch_ff),
      .rd_data (rd_word)
   );

   // ---------------- update stage ----------------
   logic                b_v_ff;
   logic                b_last_ff;
   logic [CH_BITS-1:0]  b_ch_ff;
   logic [SENSOR_W-1:0] b_sens_ff;
   // entry valid bits stand in for the zero reset of the ram
   logic [CHANNELS-1:0] entry_v_ff;
   logic                rd_v_ff;
   // forward a write that collided with the read of the same entry
   logic                fwd_v_ff;
   logic [WORD_W-1:0]   fwd_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff     <= 1'b0;
         entry_v_ff <= '0;
         fwd_v_ff   <= 1'b0;
      end else begin
         b_v_ff   <= busy_ff;
         fwd_v_ff <= busy_ff && wr_en && (wr_addr == ch_ff);
         if (wr_en) begin
            entry_v_ff[wr_addr] <= 1'b1;
         end
      end
      b_last_ff   <= ch_last;
      b_ch_ff     <= ch_ff;
      b_sens_ff   <= sens_ff;
      rd_v_ff     <= entry_v_ff[ch_ff];
      fwd_word_ff <= wr_word;
   end

   logic [WORD_W-1:0]   cur_word;
   logic [CHANNELS-1:0] sens_ext;
   logic [CHANNELS-1:0] pol_ext;

   assign cur_word = fwd_v_ff ? fwd_word_ff : (rd_v_ff ? rd_word : '0);

   // channels past the four sensor bits see level zero and polarity clear
   for (genvar gi = 0; gi < CHANNELS; gi++) begin : g_ext
      if (gi < SENSOR_W) begin : g_in
         assign sens_ext[gi] = b_sens_ff[gi];
         assign pol_ext[gi]  = cfg_ff.polarity_low[gi];
      end else begin : g_out
         assign sens_ext[gi] = 1'b0;
         assign pol_ext[gi]  = 1'b0;
      end
   end

   // flag bits live in flops, one bit per channel
   logic [CHANNELS-1:0] prev_ff;
   logic [CHANNELS-1:0] lamp_ff;
   logic [CHANNELS-1:0] fading_ff;
   logic [CHANNELS-1:0] prev_in;
   logic [CHANNELS-1:0] lamp_in;
   logic [CHANNELS-1:0] fading_in;

   dlf_chin_type          ch_flags;
   dlf_chout_type         ch_flags_new;
   logic [CNT_W-1:0]      ticks_new;
   logic [LEVEL_BITS-1:0] tgt_new;
   logic [LEVEL_BITS-1:0] cur_new;

   assign ch_flags.now    = sens_ext[b_ch_ff];
   assign ch_flags.prev   = prev_ff[b_ch_ff];
   assign ch_flags.pol    = pol_ext[b_ch_ff];
   assign ch_flags.lamp   = lamp_ff[b_ch_ff];
   assign ch_flags.fading = fading_ff[b_ch_ff];

   dlf_chan_update #(
      .LEVEL_BITS (LEVEL_BITS)
   ) u_chan_update (
      .cfg         (cfg_ff),
      .flags       (ch_flags),
      .ticks       (cur_word[TCK_LO +: CNT_W]),
      .target      (cur_word[TGT_LO +: LEVEL_BITS]),
      .current     (cur_word[CUR_LO +: LEVEL_BITS]),
      .ticks_new   (ticks_new),
      .target_new  (tgt_new),
      .current_new (cur_new),
      .flags_new   (ch_flags_new)
   );

   assign wr_en   = b_v_ff;
   assign wr_addr = b_ch_ff;
   assign wr_word = {ticks_new, tgt_new, cur_new};

   always_comb begin
      prev_in   = prev_ff;
      lamp_in   = lamp_ff;
      fading_in = fading_ff;
      if (b_v_ff) begin
         prev_in[b_ch_ff]   = ch_flags.now;
         lamp_in[b_ch_ff]   = ch_flags_new.lamp;
         fading_in[b_ch_ff] = ch_flags_new.fading;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= '0;
         lamp_ff   <= '0;
         fading_ff <= '0;
      end else begin
         prev_ff   <= prev_in;
         lamp_ff   <= lamp_in;
         fading_ff <= fading_in;
      end
   end

   // ---------------- result assembly ----------------
   // levels of the channels already done in this item are gathered here
   logic [CHANNELS-1:0][LEVEL_BITS-1:0] coll_ff;

   always_ff @(posedge clock) begin
      if (b_v_ff) begin
         coll_ff[b_ch_ff] <= cur_new;
      end
   end

   logic        produce;
   dlf_rsp_type rsp_new;
   dlf_rsp_type rsp_data;

   assign produce = b_v_ff && b_last_ff;

   for (genvar go = 0; go < OUT_CH; go++) begin : g_rsp
      if (go < CHANNELS) begin : g_live
         assign rsp_new.level[go] = (b_ch_ff == CH_BITS'(go)) ?
                                    OUT_LVL_W'(cur_new) : OUT_LVL_W'(coll_ff[go]);
         assign rsp_new.lamp_on[go] = lamp_in[go];
         assign rsp_new.fading[go]  = fading_in[go];
      end else begin : g_none
         assign rsp_new.level[go]   = '0;
         assign rsp_new.lamp_on[go] = 1'b0;
         assign rsp_new.fading[go]  = 1'b0;
      end
   end

   dlf_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (produce),
      .push_data (rsp_new),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_level_ch0    = rsp_data.level[0];
   assign rsp_level_ch1    = rsp_data.level[1];
   assign rsp_level_ch2    = rsp_data.level[2];
   assign rsp_level_ch3    = rsp_data.level[3];
   assign rsp_lamp_on_mask = rsp_data.lamp_on;
   assign rsp_fading_mask  = rsp_data.fading;

   // ---------------- checks ----------------
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= PEND_MAX)
      else $error("more beats in flight than the result buffer holds");

   a_produce_last_ch: assert property (@(posedge clock) disable iff (reset)
      produce |-> (b_ch_ff == CH_LAST) && (pend_ff != 2'd0))
      else $error("result formed on a channel other than the last");

   a_rsp_has_owner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pend_ff != 2'd0))
      else $error("result beat offered with no accepted beat pending");

endmodule

`default_nettype wire
